// File: rtl/assert_macros.svh
// Assertion macros used by the core RTL file of the argument splitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/cmdsplit_pkg.sv
// Types and constants of the command line argument splitter.
package cmdsplit_pkg;

   localparam int MAX_RUN = 63;
   localparam int RUN_W   = 6;
   localparam logic [RUN_W-1:0] RUN_CAP = (MAX_RUN > 63) ? RUN_W'(63) : RUN_W'(MAX_RUN);

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   localparam logic [7:0] MAX_ARGS_RESET = 8'd255;

   typedef struct packed {
      logic             in_quote;
      logic             in_word;
      logic [RUN_W-1:0] run;
      logic [7:0]       word_count;
      logic             limit_hit;
   } state_type;

   typedef struct packed {
      logic [RUN_W-1:0] backslash_count;
      logic             has_char;
      logic [7:0]       char_out;
      logic             word_end;
      logic [7:0]       word_index;
      logic             done_res;
   } result_type;

endpackage

// File: rtl/cmdsplit_step.sv
// Next-state and result logic for one command line byte.
module cmdsplit_step
   import cmdsplit_pkg::*;
(
   input  state_type  state,
   input  logic [7:0] max_args,
   input  logic [7:0] char_in,
   input  logic       end_of_line,
   output state_type  next_state,
   output logic       res_valid,
   output result_type res
);

   logic [7:0]       limit;
   logic             is_sep;
   logic [RUN_W-1:0] run_eff;
   logic             quote_eff;
   logic [7:0]       count_inc;

   assign limit     = (max_args == 8'd0) ? 8'd0 : max_args - 8'd1;
   assign is_sep    = (char_in == CH_SPACE) || (char_in == CH_TAB);
   assign run_eff   = state.in_word ? state.run : '0;
   assign quote_eff = state.in_word ? state.in_quote : 1'b0;
   assign count_inc = state.word_count + 8'd1;

   always_comb begin
      next_state = state;
      res_valid  = 1'b0;
      res        = '0;
      res.word_index = state.word_count;
      if (end_of_line) begin
         res_valid    = 1'b1;
         res.done_res = 1'b1;
         if (state.in_word) begin
            res.backslash_count = state.run;
            res.word_end        = 1'b1;
            res.word_index      = count_inc;
         end
         next_state = '0;
      end else if (state.limit_hit) begin
         // drop every byte up to end of line
         next_state = state;
      end else if (!state.in_word && is_sep) begin
         next_state = state;
      end else if (!state.in_word && (state.word_count >= limit)) begin
         next_state.limit_hit = 1'b1;
      end else begin
         next_state.in_word  = 1'b1;
         next_state.in_quote = quote_eff;
         next_state.run      = '0;
         if (char_in == CH_BSLASH) begin
            // saturate the run
            next_state.run = (run_eff < RUN_CAP) ? run_eff + RUN_W'(1) : run_eff;
         end else if (char_in == CH_QUOTE) begin
            res_valid           = 1'b1;
            res.backslash_count = run_eff >> 1;
            if (run_eff[0]) begin
               res.has_char = 1'b1;
               res.char_out = CH_QUOTE;
            end else begin
               next_state.in_quote = !quote_eff;
            end
         end else if (!quote_eff && is_sep) begin
            res_valid             = 1'b1;
            res.backslash_count   = run_eff;
            res.word_end          = 1'b1;
            next_state.word_count = count_inc;
            next_state.in_word    = 1'b0;
            next_state.in_quote   = 1'b0;
            next_state.limit_hit  = (count_inc >= limit);
         end else begin
            res_valid           = 1'b1;
            res.backslash_count = run_eff;
            res.has_char        = 1'b1;
            res.char_out        = char_in;
         end
      end
   end

endmodule

// File: rtl/command_line_argument_splitter_core.sv
// A result beat is registered and appears in the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle while the result register can drain; the state update
// and result decode sit between the line state registers and the result register.
// A stalled result register holds req_tready low until it drains.
// Reset (synchronous, active high) clears the line state and sets max_args to 255.
`include "assert_macros.svh"
module command_line_argument_splitter_core
   import cmdsplit_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic        req_tlast,   // end_of_line
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [5:0] backslash_count, [6] has_char,
                                    // [14:7] char_out, [22:15] word_index, [23] zero
   output logic        rsp_tlast,   // word_end
   output logic        rsp_tuser    // done_res
);

   logic [7:0] max_args_reg_ff;
   state_type  state_ff, state_in, step_state;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in, step_res;
   logic       step_valid;
   logic       req_fire;

   assign req_tready  = !rsp_valid_ff || rsp_tready;
   assign req_fire    = req_tvalid && req_tready;

   cmdsplit_step u_step (
      .state       (state_ff),
      .max_args    (max_args_reg_ff),
      .char_in     (req_tdata),
      .end_of_line (req_tlast),
      .next_state  (step_state),
      .res_valid   (step_valid),
      .res         (step_res)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (req_fire) begin
         state_in     = step_state;
         rsp_valid_in = step_valid;
         rsp_in       = step_res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_args_reg_ff <= MAX_ARGS_RESET;
         state_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_args_reg_ff <= csr_wr_data;
         end
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.word_index, rsp_ff.char_out,
                        rsp_ff.has_char, rsp_ff.backslash_count};
   assign rsp_tlast  = rsp_ff.word_end;
   assign rsp_tuser  = rsp_ff.done_res;

   `ASSERT_ALWAYS(a_run_cap, clock, reset, state_ff.run <= RUN_CAP)
   `ASSERT_NEXT(a_eol_result, clock, reset, req_fire && req_tlast, rsp_tvalid && rsp_tuser)
   `ASSERT_NEXT(a_eol_clear, clock, reset, req_fire && req_tlast,
                !state_ff.in_word && (state_ff.word_count == 8'd0) && !state_ff.limit_hit)
   `ASSERT_IMPLIES(a_done_no_char, clock, reset, rsp_tvalid && rsp_tuser, !rsp_ff.has_char)

endmodule

// File: dv/command_line_argument_splitter_core_tb.sv
// Self-checking testbench for the command line argument splitter core.
`timescale 1ns / 1ps
module command_line_argument_splitter_core_tb
   import cmdsplit_pkg::*;
();

   localparam int STALL_LIMIT  = 3000;
   localparam int LONG_HOLD    = 80;
   localparam int PHASE_BEATS  = 80;
   localparam int SETTLE_TICKS = 4;
   localparam int REPORT_CAP   = 40;

   typedef struct packed {
      logic [7:0] ch;
      logic       eol;
      logic       typed;
      logic       yields;
      result_type piece;
   } probe_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = 8'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;    // [7:0] char_in
   logic        req_tlast = 1'b0;    // end_of_line
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // [5:0] backslash_count, [6] has_char,
                                     // [14:7] char_out, [22:15] word_index, [23] zero
   logic        rsp_tlast;           // word_end
   logic        rsp_tuser;           // done_res

   // splitter state as the predictor sees it
   logic       quoting = 1'b0;
   logic       in_arg = 1'b0;
   logic [5:0] bs_run = '0;
   logic [7:0] arg_count = '0;
   logic       arg_cap_hit = 1'b0;
   logic [7:0] argv_size = MAX_ARGS_RESET;

   result_type pieces_due[$];
   result_type seen_piece;
   result_type want_piece;
   int         mismatch_count = 0;
   int         beats_sent = 0;
   int         stall_cycles = 0;
   int         sink_wait = 0;
   int         hold_ask_n = 0;
   int         hold_done_n = 0;
   bit         src_quiet = 1'b0;
   bit         sink_quiet = 1'b0;

   logic [7:0] argv_plan [6] = '{8'd1, 8'd0, 8'd2, 8'd3, 8'd128, 8'd255};

   probe_row_type probe_rows [24] = '{
      '{8'h00,     1'b1, 1'b1, 1'b1, '{6'd0, 1'b0, 8'h00, 1'b0, 8'd0, 1'b1}},
      '{8'h61,     1'b0, 1'b1, 1'b1, '{6'd0, 1'b1, 8'h61, 1'b0, 8'd0, 1'b0}},
      '{8'h00,     1'b0, 1'b1, 1'b1, '{6'd0, 1'b1, 8'h00, 1'b0, 8'd0, 1'b0}},
      '{8'hFF,     1'b0, 1'b1, 1'b1, '{6'd0, 1'b1, 8'hFF, 1'b0, 8'd0, 1'b0}},
      '{CH_SPACE,  1'b0, 1'b1, 1'b1, '{6'd0, 1'b0, 8'h00, 1'b1, 8'd0, 1'b0}},
      '{CH_SPACE,  1'b0, 1'b1, 1'b0, '0},
      '{CH_TAB,    1'b0, 1'b1, 1'b0, '0},
      '{CH_BSLASH, 1'b0, 1'b1, 1'b0, '0},
      '{CH_BSLASH, 1'b0, 1'b1, 1'b0, '0},
      '{CH_BSLASH, 1'b0, 1'b1, 1'b0, '0},
      '{CH_QUOTE,  1'b0, 1'b0, 1'b0, '0},
      '{CH_QUOTE,  1'b0, 1'b0, 1'b0, '0},
      '{CH_SPACE,  1'b0, 1'b0, 1'b0, '0},
      '{CH_QUOTE,  1'b0, 1'b0, 1'b0, '0},
      '{CH_BSLASH, 1'b0, 1'b0, 1'b0, '0},
      '{CH_BSLASH, 1'b0, 1'b0, 1'b0, '0},
      '{CH_TAB,    1'b0, 1'b0, 1'b0, '0},
      '{CH_BSLASH, 1'b0, 1'b0, 1'b0, '0},
      '{8'h00,     1'b1, 1'b0, 1'b0, '0},
      '{8'hFF,     1'b1, 1'b1, 1'b1, '{6'd0, 1'b0, 8'h00, 1'b0, 8'd0, 1'b1}},
      '{8'h71,     1'b0, 1'b0, 1'b0, '0},
      '{CH_QUOTE,  1'b0, 1'b0, 1'b0, '0},
      '{CH_TAB,    1'b0, 1'b0, 1'b0, '0},
      '{8'h5A,     1'b1, 1'b0, 1'b0, '0}
   };

   command_line_argument_splitter_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the splitter state by one byte; return 1 when a piece comes out.
   function automatic bit split_byte(input logic [7:0] c, input logic eol,
                                     output result_type piece);
      logic [5:0] run;
      logic [7:0] arg_limit;
      bit         is_sep;
      piece     = '0;
      run       = bs_run;
      arg_limit = (argv_size == 8'd0) ? 8'd0 : argv_size - 8'd1;
      is_sep    = (c == CH_SPACE) || (c == CH_TAB);
      if (eol) begin
         piece.done_res   = 1'b1;
         piece.word_index = arg_count;
         if (in_arg) begin
            piece.backslash_count = run;
            piece.word_end        = 1'b1;
            piece.word_index      = arg_count + 8'd1;
         end
         quoting     = 1'b0;
         in_arg      = 1'b0;
         bs_run      = '0;
         arg_count   = '0;
         arg_cap_hit = 1'b0;
         return 1'b1;
      end
      if (arg_cap_hit)
         return 1'b0;
      if (!in_arg) begin
         if (is_sep)
            return 1'b0;
         if (arg_count >= arg_limit) begin
            arg_cap_hit = 1'b1;
            return 1'b0;
         end
         in_arg  = 1'b1;
         quoting = 1'b0;
         bs_run  = '0;
         run     = '0;
      end
      if (c == CH_BSLASH) begin
         if (run < RUN_CAP)
            bs_run = run + 6'd1;
         return 1'b0;
      end
      bs_run           = '0;
      piece.word_index = arg_count;
      if (c == CH_QUOTE) begin
         piece.backslash_count = run >> 1;
         // odd run escapes the quote, even run toggles quoting
         if (run[0]) begin
            piece.has_char = 1'b1;
            piece.char_out = CH_QUOTE;
         end else begin
            quoting = !quoting;
         end
         return 1'b1;
      end
      piece.backslash_count = run;
      if (!quoting && is_sep) begin
         piece.word_end = 1'b1;
         arg_count      = arg_count + 8'd1;
         in_arg         = 1'b0;
         quoting        = 1'b0;
         if (arg_count >= arg_limit)
            arg_cap_hit = 1'b1;
         return 1'b1;
      end
      piece.has_char = 1'b1;
      piece.char_out = c;
      return 1'b1;
   endfunction

   function automatic int idle_len();
      return ($urandom_range(0, 99) < 75) ? $urandom_range(1, 3) : $urandom_range(6, 30);
   endfunction

   function automatic logic [7:0] pick_byte(input bit noisy);
      int r;
      r = $urandom_range(0, 99);
      if (noisy || r >= 90)
         return 8'($urandom_range(0, 255));
      if (r < 40)
         return 8'($urandom_range(8'h21, 8'h7E));
      if (r < 55)
         return CH_SPACE;
      if (r < 62)
         return CH_TAB;
      if (r < 76)
         return CH_BSLASH;
      return CH_QUOTE;
   endfunction

   // Offer one beat, hold it until taken, then predict what it yields (typed beats take the given piece).
   task automatic send_beat(input logic [7:0] ch, input logic eol, input logic typed,
                            input logic yields, input result_type piece);
      int         gap;
      bit         made;
      result_type guess;
      gap = (src_quiet || $urandom_range(0, 2) != 0) ? 0 : idle_len();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= eol;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
      made = split_byte(ch, eol, guess);
      if (typed) begin
         made  = yields;
         guess = piece;
      end
      if (made)
         pieces_due.push_back(guess);
   endtask

   task automatic send_line(input int max_len);
      int len;
      int k;
      int burst;
      bit noisy;
      len   = $urandom_range(1, max_len);
      noisy = ($urandom_range(0, 9) == 0);
      k     = 0;
      while (k < len) begin
         if ($urandom_range(0, 149) == 0) begin
            // long backslash run, which can push the count into saturation
            burst = $urandom_range(60, 70);
            repeat (burst) send_beat(CH_BSLASH, 1'b0, 1'b0, 1'b0, '0);
            k += burst;
         end else begin
            send_beat(pick_byte(noisy), 1'b0, 1'b0, 1'b0, '0);
            k++;
         end
      end
      send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0, '0);
   endtask

   // Drop valid and wait for every expected piece plus the block's tail latency.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pieces_due.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic argv_write(input logic [7:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      argv_size = value;
      csr_wr_en   <= 1'b0;
   endtask

   // sink side: random holds, one long hold on request, quiet stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_ask_n != hold_done_n) begin
         hold_done_n <= hold_ask_n;
         sink_wait   <= LONG_HOLD;
         rsp_tready  <= 1'b0;
      end else if (sink_wait != 0) begin
         sink_wait  <= sink_wait - 1;
         rsp_tready <= (sink_wait == 1);
      end else if (!sink_quiet && $urandom_range(0, 3) == 0) begin
         sink_wait  <= idle_len();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_piece.backslash_count = rsp_tdata[5:0];
         seen_piece.has_char        = rsp_tdata[6];
         seen_piece.char_out        = rsp_tdata[14:7];
         seen_piece.word_index      = rsp_tdata[22:15];
         seen_piece.word_end        = rsp_tlast;
         seen_piece.done_res        = rsp_tuser;
         if (pieces_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_CAP)
               $display("%0t: unexpected beat %h last=%b user=%b", $time, rsp_tdata,
                        rsp_tlast, rsp_tuser);
         end else begin
            want_piece = pieces_due.pop_front();
            if (seen_piece !== want_piece || rsp_tdata[23] !== 1'b0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_CAP)
                  $display({"%0t: mismatch exp bs=%0d has=%b ch=%h end=%b idx=%0d done=%b",
                            " | act bs=%0d has=%b ch=%h end=%b idx=%0d done=%b pad=%b"},
                           $time, want_piece.backslash_count, want_piece.has_char,
                           want_piece.char_out, want_piece.word_end,
                           want_piece.word_index, want_piece.done_res,
                           seen_piece.backslash_count, seen_piece.has_char,
                           seen_piece.char_out, seen_piece.word_end,
                           seen_piece.word_index, seen_piece.done_res, rsp_tdata[23]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int target;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (probe_rows[i])
         send_beat(probe_rows[i].ch, probe_rows[i].eol, probe_rows[i].typed,
                   probe_rows[i].yields, probe_rows[i].piece);
      settle();
      foreach (argv_plan[p]) begin
         argv_write(argv_plan[p]);
         sink_quiet = (p == 3);
         target     = beats_sent + PHASE_BEATS;
         if (p == 4) begin
            // stall the sink and offer one line of back-to-back beats so the input backs up
            hold_ask_n++;
            src_quiet = 1'b1;
            send_line(40);
            src_quiet = 1'b0;
         end
         while (beats_sent < target) send_line(24);
         settle();
      end
      sink_quiet = 1'b0;
      if (mismatch_count == 0 && pieces_due.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/cmdsplit_pkg.sv
rtl/cmdsplit_step.sv
rtl/command_line_argument_splitter_core.sv
dv/command_line_argument_splitter_core_tb.sv
